>>> design/sdg_pkg.sv
// ----------------------------------------------------------------------------
// sdg_pkg
// shared widths, register indexes and side-band types for the sphere sdf block
// ----------------------------------------------------------------------------
package sdg_pkg;

  localparam int CoordW = 24;
  localparam int DiffW  = 25;
  localparam int MagW   = 25;
  localparam int SqW    = 50;
  localparam int DistW  = 25;
  localparam int RadW   = 23;
  localparam int SdW    = 27;
  localparam int GradW  = 18;
  localparam int QuotW  = 17;
  localparam int Lanes  = 3;

  typedef enum logic [2:0] {
    REG_CENTER_X = 3'd0,
    REG_CENTER_Y = 3'd1,
    REG_CENTER_Z = 3'd2,
    REG_RADIUS   = 3'd3,
    REG_OUTWARD  = 3'd4
  } reg_idx_t;

  // per-axis magnitude and sign of the centre-to-point difference
  typedef struct packed {
    logic [Lanes-1:0]           neg;
    logic [Lanes-1:0][MagW-1:0] mag;
  } side_t;

endpackage

>>> design/sdg_sqrt.sv
// ----------------------------------------------------------------------------
// sdg_sqrt
// pipelined truncating square root, one result bit per stage
// ----------------------------------------------------------------------------
module sdg_sqrt (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            en,
  input  logic                            valid_i,
  input  logic [sdg_pkg::SqW-1:0]         sq_i,
  input  sdg_pkg::side_t                  side_i,
  output logic                            valid_o,
  output logic [sdg_pkg::DistW-1:0]       root_o,
  output sdg_pkg::side_t                  side_o
);

  localparam int Steps = sdg_pkg::DistW;
  localparam int RemW  = sdg_pkg::SqW + 1;

  logic [RemW-1:0]              rem_p   [Steps+1];
  logic [sdg_pkg::DistW-1:0]    root_p  [Steps+1];
  logic                         val_p   [Steps+1];
  sdg_pkg::side_t               side_p  [Steps+1];

  assign rem_p[0]  = {1'b0, sq_i};
  assign root_p[0] = '0;
  assign val_p[0]  = valid_i;
  assign side_p[0] = side_i;

  for (genvar s = 0; s < Steps; s++) begin : g_step
    localparam int B = Steps - 1 - s;
    logic [RemW-1:0] trial;
    logic            take;

    // (root + 2^B)^2 - root^2
    assign trial = ({{(RemW - sdg_pkg::DistW){1'b0}}, root_p[s]} << (B + 1))
                 + ({{(RemW - 1){1'b0}}, 1'b1} << (2 * B));
    assign take  = (rem_p[s] >= trial);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        val_p[s+1] <= 1'b0;
      end else if (en) begin
        val_p[s+1] <= val_p[s];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_p[s+1]  <= take ? (rem_p[s] - trial) : rem_p[s];
        root_p[s+1] <= root_p[s] | ({{(sdg_pkg::DistW - 1){1'b0}}, take} << B);
        side_p[s+1] <= side_p[s];
      end
    end
  end

  assign valid_o = val_p[Steps];
  assign root_o  = root_p[Steps];
  assign side_o  = side_p[Steps];

endmodule

>>> design/sdg_grad.sv
// ----------------------------------------------------------------------------
// sdg_grad
// signed distance and pipelined rounded division of the gradient components
// ----------------------------------------------------------------------------
module sdg_grad (
  input  logic                                              clk,
  input  logic                                              rst_n,
  input  logic                                              en,
  input  logic                                              valid_i,
  input  logic [sdg_pkg::DistW-1:0]                         dist_i,
  input  sdg_pkg::side_t                                    side_i,
  input  logic [sdg_pkg::RadW-1:0]                          radius_i,
  input  logic                                              outward_i,
  output logic                                              valid_o,
  output logic signed [sdg_pkg::SdW-1:0]                    sd_o,
  output logic [sdg_pkg::Lanes-1:0][sdg_pkg::GradW-1:0]     grad_o
);

  localparam int Steps = sdg_pkg::QuotW;
  localparam int NumW  = sdg_pkg::MagW + 17;
  localparam int RemW  = sdg_pkg::DistW + 1;
  localparam int L     = sdg_pkg::Lanes;

  // prep stage
  logic                              pv_r;
  logic signed [sdg_pkg::SdW-1:0]    psd_r;
  logic [sdg_pkg::DistW-1:0]         pden_r;
  logic [L-1:0]                      pflip_r;
  logic                              pzero_r;
  logic [L-1:0][NumW-1:0]            pnum_r;

  logic signed [sdg_pkg::SdW-1:0]    sd_raw;
  logic [L-1:0][NumW-1:0]            num_nxt;

  assign sd_raw = $signed({2'b00, dist_i}) - $signed({4'b0000, radius_i});

  always_comb begin
    for (int l = 0; l < L; l++) begin
      num_nxt[l] = {1'b0, side_i.mag[l], 16'b0}
                 + {{(NumW - sdg_pkg::DistW + 1){1'b0}}, dist_i[sdg_pkg::DistW-1:1]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r <= 1'b0;
    end else if (en) begin
      pv_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      psd_r   <= outward_i ? -sd_raw : sd_raw;
      pden_r  <= dist_i;
      pflip_r <= side_i.neg ^ {L{outward_i}};
      pzero_r <= (dist_i == '0);
      pnum_r  <= num_nxt;
    end
  end

  // restoring division chain
  logic [RemW-1:0]                   rem_p  [L][Steps+1];
  logic [Steps-1:0]                  lo_p   [L][Steps+1];
  logic [Steps-1:0]                  q_p    [L][Steps+1];
  logic                              val_p  [Steps+1];
  logic signed [sdg_pkg::SdW-1:0]    sd_p   [Steps+1];
  logic [sdg_pkg::DistW-1:0]         den_p  [Steps+1];
  logic [L-1:0]                      flip_p [Steps+1];
  logic                              zero_p [Steps+1];

  assign val_p[0]  = pv_r;
  assign sd_p[0]   = psd_r;
  assign den_p[0]  = pden_r;
  assign flip_p[0] = pflip_r;
  assign zero_p[0] = pzero_r;

  for (genvar l = 0; l < L; l++) begin : g_lane_in
    assign rem_p[l][0] = {1'b0, pnum_r[l][NumW-1:Steps]};
    assign lo_p[l][0]  = pnum_r[l][Steps-1:0];
    assign q_p[l][0]   = '0;
  end

  for (genvar s = 0; s < Steps; s++) begin : g_step
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        val_p[s+1] <= 1'b0;
      end else if (en) begin
        val_p[s+1] <= val_p[s];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sd_p[s+1]   <= sd_p[s];
        den_p[s+1]  <= den_p[s];
        flip_p[s+1] <= flip_p[s];
        zero_p[s+1] <= zero_p[s];
      end
    end

    for (genvar l = 0; l < L; l++) begin : g_lane
      logic [RemW-1:0] r2;
      logic            take;

      assign r2   = {rem_p[l][s][RemW-2:0], lo_p[l][s][Steps-1]};
      assign take = (r2 >= {1'b0, den_p[s]});

      always_ff @(posedge clk) begin
        if (en) begin
          rem_p[l][s+1] <= take ? (r2 - {1'b0, den_p[s]}) : r2;
          lo_p[l][s+1]  <= {lo_p[l][s][Steps-2:0], 1'b0};
          q_p[l][s+1]   <= {q_p[l][s][Steps-2:0], take};
        end
      end
    end
  end

  // output stage: apply sign, zero gradient at the centre
  logic                                   ov_r;
  logic signed [sdg_pkg::SdW-1:0]         osd_r;
  logic [L-1:0][sdg_pkg::GradW-1:0]       ograd_r;
  logic [L-1:0][sdg_pkg::GradW-1:0]       grad_nxt;

  always_comb begin
    for (int l = 0; l < L; l++) begin
      if (zero_p[Steps]) begin
        grad_nxt[l] = '0;
      end else if (flip_p[Steps][l]) begin
        grad_nxt[l] = -{1'b0, q_p[l][Steps]};
      end else begin
        grad_nxt[l] = {1'b0, q_p[l][Steps]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (en) begin
      ov_r <= val_p[Steps];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      osd_r   <= sd_p[Steps];
      ograd_r <= grad_nxt;
    end
  end

  assign valid_o = ov_r;
  assign sd_o    = osd_r;
  assign grad_o  = ograd_r;

endmodule

>>> design/sphere_signed_distance_gradient_top.sv
// ----------------------------------------------------------------------------
// sphere_signed_distance_gradient_top
// signed distance and unit gradient of a query point against a sphere
// ----------------------------------------------------------------------------
// stages from input transaction to result: diff, square, sum, 25 square-root
//   stages, prep, 17 divider stages, output sign stage
// throughput: one point per cycle when not stalled, set by the fully pipelined root and divider
// the whole pipeline holds while the output register waits on out_tready
// reset: synchronous rst_n clears valid bits; centre 0, radius 1.0, outward 1
module sphere_signed_distance_gradient_top (
  input  logic         clk,
  input  logic         rst_n,
  // configuration write channel
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [23:0]  cfg_data,
  // query point: point_x [23:0], point_y [47:24], point_z [71:48]
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [71:0]  in_tdata,
  // result: signed_distance [26:0], grad_x [44:27], grad_y [62:45],
  // grad_z [80:63], zero fill [87:81]
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [87:0]  out_tdata
);

  localparam int W  = sdg_pkg::CoordW;
  localparam int DW = sdg_pkg::DiffW;
  localparam int L  = sdg_pkg::Lanes;

  // configuration registers
  logic signed [W-1:0]           cx_r, cy_r, cz_r;
  logic [sdg_pkg::RadW-1:0]      radius_r;
  logic                          outward_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cx_r      <= '0;
      cy_r      <= '0;
      cz_r      <= '0;
      radius_r  <= sdg_pkg::RadW'(65536);
      outward_r <= 1'b1;
    end else if (cfg_valid) begin
      case (cfg_index)
        sdg_pkg::REG_CENTER_X: cx_r      <= cfg_data;
        sdg_pkg::REG_CENTER_Y: cy_r      <= cfg_data;
        sdg_pkg::REG_CENTER_Z: cz_r      <= cfg_data;
        sdg_pkg::REG_RADIUS:   radius_r  <= cfg_data[sdg_pkg::RadW-1:0];
        sdg_pkg::REG_OUTWARD:  outward_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // global advance: every pipeline stage moves unless the result register is stalled
  logic en;
  assign en        = out_tready || !out_tvalid;
  assign in_tready = en;

  // stage 1: centre-to-point difference
  logic                          v1_r;
  logic [L-1:0][DW-1:0]          d1_r;
  logic [L-1:0][DW-1:0]          d_nxt;
  logic signed [L-1:0][W-1:0]    ctr;

  assign ctr = {cz_r, cy_r, cx_r};

  always_comb begin
    for (int l = 0; l < L; l++) begin
      d_nxt[l] = DW'($signed({in_tdata[l*W + W-1], in_tdata[l*W +: W]})
                   - $signed({ctr[l][W-1], ctr[l]}));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d1_r <= d_nxt;
    end
  end

  // stage 2: squares, plus magnitude and sign of each axis
  logic                                v2_r;
  logic [L-1:0][sdg_pkg::SqW-1:0]      sq2_r;
  sdg_pkg::side_t                      side2_r;
  sdg_pkg::side_t                      side_nxt;
  logic [L-1:0][sdg_pkg::SqW-1:0]      sq_nxt;

  always_comb begin
    for (int l = 0; l < L; l++) begin
      side_nxt.neg[l] = d1_r[l][DW-1];
      side_nxt.mag[l] = d1_r[l][DW-1] ? (~d1_r[l] + 1'b1) : d1_r[l];
      sq_nxt[l]       = {{(sdg_pkg::SqW - DW){1'b0}}, side_nxt.mag[l]}
                      * {{(sdg_pkg::SqW - DW){1'b0}}, side_nxt.mag[l]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq2_r   <= sq_nxt;
      side2_r <= side_nxt;
    end
  end

  // stage 3: squared length, below 2^50
  logic                         v3_r;
  logic [sdg_pkg::SqW-1:0]      sum3_r;
  sdg_pkg::side_t               side3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sum3_r  <= sq2_r[0] + sq2_r[1] + sq2_r[2];
      side3_r <= side2_r;
    end
  end

  // square root
  logic                          vr;
  logic [sdg_pkg::DistW-1:0]     root_dist;
  sdg_pkg::side_t                side_r4;

  sdg_sqrt u_sqrt (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .valid_i (v3_r),
    .sq_i    (sum3_r),
    .side_i  (side3_r),
    .valid_o (vr),
    .root_o  (root_dist),
    .side_o  (side_r4)
  );

  // distance and gradient division
  logic signed [sdg_pkg::SdW-1:0]         sd;
  logic [L-1:0][sdg_pkg::GradW-1:0]       grad;

  sdg_grad u_grad (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .valid_i   (vr),
    .dist_i    (root_dist),
    .side_i    (side_r4),
    .radius_i  (radius_r),
    .outward_i (outward_r),
    .valid_o   (out_tvalid),
    .sd_o      (sd),
    .grad_o    (grad)
  );

  assign out_tdata = {7'b0, grad[2], grad[1], grad[0], sd};

endmodule

>>> bench/sdg_checker.sv
// ----------------------------------------------------------------------------
// sdg_checker
// watches the config, query and result channels of the sphere sdf block,
// predicts each result from its own copy of the registers and compares
// ----------------------------------------------------------------------------
module sdg_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_data,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [71:0] in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [87:0] out_tdata,
  output int          fail_count,
  output int          pending
);

  logic signed [23:0] cen_x, cen_y, cen_z;
  logic [22:0]        rad;
  logic               outward;
  logic [87:0]        sdf_queue[$];

  assign pending = sdf_queue.size();

  function automatic logic [63:0] root_floor(logic [63:0] v);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic [17:0] unit_comp(longint d, longint len, logic flip);
    longint m, g;
    if (len == 0) return '0;
    m = (d < 0) ? -d : d;
    m = ((m << 16) + (len >> 1)) / len;
    g = (d < 0) ? -m : m;
    if (flip) g = -g;
    return g[17:0];
  endfunction

  function automatic logic [87:0] sphere_sdf(logic [71:0] p);
    longint dx, dy, dz, len, sd;
    logic [63:0] sq;
    dx = longint'($signed(p[23:0])) - cen_x;
    dy = longint'($signed(p[47:24])) - cen_y;
    dz = longint'($signed(p[71:48])) - cen_z;
    sq = dx * dx + dy * dy + dz * dz;
    len = longint'(root_floor(sq));
    sd = len - longint'(rad);
    if (outward) sd = -sd;
    return {7'd0, unit_comp(dz, len, outward), unit_comp(dy, len, outward),
            unit_comp(dx, len, outward), sd[26:0]};
  endfunction

  always @(posedge clk) begin
    logic [87:0] want;
    if (!rst_n) begin
      cen_x <= '0; cen_y <= '0; cen_z <= '0;
      rad <= 23'd65536; outward <= 1'b1;
      fail_count <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          sdg_pkg::REG_CENTER_X: cen_x <= cfg_data;
          sdg_pkg::REG_CENTER_Y: cen_y <= cfg_data;
          sdg_pkg::REG_CENTER_Z: cen_z <= cfg_data;
          sdg_pkg::REG_RADIUS:   rad <= cfg_data[22:0];
          sdg_pkg::REG_OUTWARD:  outward <= cfg_data[0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) sdf_queue.push_back(sphere_sdf(in_tdata));
      if (out_tvalid && out_tready) begin
        if (sdf_queue.size() == 0) begin
          if (fail_count < 10) $display("unexpected result %h", out_tdata);
          fail_count <= fail_count + 1;
        end else begin
          want = sdf_queue.pop_front();
          if (want !== out_tdata) begin
            if (fail_count < 10)
              $display("mismatch dist %h/%h gx %h/%h gy %h/%h gz %h/%h",
                       want[26:0], out_tdata[26:0], want[44:27], out_tdata[44:27],
                       want[62:45], out_tdata[62:45], want[80:63], out_tdata[80:63]);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

>>> bench/sphere_signed_distance_gradient_top_test.sv
// ----------------------------------------------------------------------------
// sphere_signed_distance_gradient_top_test
// directed and random query points against several sphere settings, with
// random gaps on both channels; the checker predicts and compares results
// ----------------------------------------------------------------------------
module sphere_signed_distance_gradient_top_test;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [23:0] cfg_data = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [71:0] in_tdata = '0;   // point_x, point_y, point_z
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [87:0] out_tdata;       // signed_distance, grad_x, grad_y, grad_z, zero fill
  int          fail_count;
  int          pending;
  bit          stim_done = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  sphere_signed_distance_gradient_top u_top (.*);

  sdg_checker u_check (.*);

  // mostly short gaps, now and then a long one
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // receiver stalls of random length, with stretches of no stall at all
  initial begin
    int n;
    while (1) begin
      n = gap_len();
      if (n != 0) begin
        out_tready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_tready <= 1'b1;
      if ($urandom_range(0, 7) == 0) begin
        repeat ($urandom_range(20, 80)) @(posedge clk);
      end else begin
        @(posedge clk);
      end
    end
  end

  // leaves cfg_valid high; the caller drops it after the last write
  task automatic reg_write(sdg_pkg::reg_idx_t idx, logic [23:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // wait for every outstanding result, then keep clocking with the input idle
  task automatic drain();
    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic send_point(logic [23:0] px, logic [23:0] py, logic [23:0] pz);
    int g;
    g = gap_len();
    if (g != 0) begin
      in_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {pz, py, px};
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic idle_input();
    in_tvalid <= 1'b0;
  endtask

  task automatic set_sphere(logic [23:0] cx, logic [23:0] cy, logic [23:0] cz,
                            logic [23:0] r, logic o);
    reg_write(sdg_pkg::REG_CENTER_X, cx);
    reg_write(sdg_pkg::REG_CENTER_Y, cy);
    reg_write(sdg_pkg::REG_CENTER_Z, cz);
    reg_write(sdg_pkg::REG_RADIUS, r);
    reg_write(sdg_pkg::REG_OUTWARD, {23'd0, o});
    cfg_valid <= 1'b0;
  endtask

  // random point: mostly near the centre, sometimes full range
  task automatic random_point(logic [23:0] cx, logic [23:0] cy, logic [23:0] cz);
    logic [23:0] p[3];
    logic [23:0] c[3];
    c = '{cx, cy, cz};
    for (int a = 0; a < 3; a++) begin
      case ($urandom_range(0, 3))
        0: p[a] = 24'($urandom);
        1: p[a] = c[a] + 24'($signed($urandom_range(0, 511)) - 256);
        2: p[a] = c[a];
        default: p[a] = c[a] + 24'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
      endcase
    end
    send_point(p[0], p[1], p[2]);
  endtask

  initial begin
    logic [23:0] cx, cy, cz;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed, reset sphere: centre, unit axes, extremes of the fields
    send_point(24'h000000, 24'h000000, 24'h000000);
    send_point(24'h010000, 24'h000000, 24'h000000);
    send_point(24'h000000, 24'hff0000, 24'h000000);
    send_point(24'h7fffff, 24'h7fffff, 24'h7fffff);
    send_point(24'h800000, 24'h800000, 24'h800000);
    send_point(24'h7fffff, 24'h800000, 24'h000001);
    send_point(24'hffffff, 24'h000001, 24'hffffff);
    send_point(24'h555555, 24'haaaaaa, 24'h123456);
    idle_input();
    drain();

    // extreme centre, largest radius, inward
    set_sphere(24'h800000, 24'h7fffff, 24'h800000, 24'h7fffff, 1'b0);
    send_point(24'h800000, 24'h7fffff, 24'h800000);
    send_point(24'h7fffff, 24'h800000, 24'h7fffff);
    send_point(24'h000000, 24'h000000, 24'h000000);
    send_point(24'h800001, 24'h7fffff, 24'h800000);
    idle_input();
    drain();

    // zero radius, outward, point at centre
    set_sphere(24'h7fffff, 24'h800000, 24'h000000, 24'h000000, 1'b1);
    send_point(24'h7fffff, 24'h800000, 24'h000000);
    send_point(24'h800000, 24'h7fffff, 24'hffffff);
    // bits above the radius width are dropped
    idle_input();
    drain();
    reg_write(sdg_pkg::REG_RADIUS, 24'hffffff);
    cfg_valid <= 1'b0;
    send_point(24'h000000, 24'h000000, 24'h000000);
    idle_input();
    drain();

    // random phases with random settings
    for (int ph = 0; ph < 8; ph++) begin
      cx = 24'($urandom); cy = 24'($urandom); cz = 24'($urandom);
      if (ph % 3 == 0) begin
        cx = cx >>> 4; cy = cy >>> 4; cz = cz >>> 4;
      end
      set_sphere(cx, cy, cz, 24'($urandom), ph[0]);
      for (int i = 0; i < 100; i++) begin
        random_point(cx, cy, cz);
        // hold off until the pipeline has emptied, once
        if (ph == 2 && i == 50) begin
          idle_input();
          while (pending != 0) @(posedge clk);
        end
      end
      idle_input();
      drain();
    end
    stim_done = 1'b1;
  end

  initial begin
    wait (stim_done);
    if (fail_count == 0 && pending == 0) begin
      $display("sphere_signed_distance_gradient_top_test passed");
    end else begin
      $display("sphere_signed_distance_gradient_top_test failed");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("sphere_signed_distance_gradient_top_test failed");
    $finish;
  end

endmodule
